[src/ghi_pkg.sv]
// Shared types and fixed constants for the gyro heading integrator.
// Depends on nothing; every other file in src but ghi_integrator imports it.
`timescale 1ns / 1ps

package ghi_pkg;

	// Word kinds on the input channel.
	localparam logic KIND_RATE = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	// Deadband register value after reset.
	localparam logic [12:0] DEADBAND_RESET = 13'd4;

	// One full turn in tenths of a degree, and the edges used for turn counting.
	localparam logic [11:0] FULL_TURN = 12'd3600;
	localparam logic [11:0] LOW_EDGE  = 12'd200;
	localparam logic [11:0] HIGH_EDGE = 12'd3400;

	// 2^16 mod 3600, used to fold the upper half of a quotient into a narrow residue.
	localparam logic [9:0] WORD_WRAP = 10'd736;

	// Reciprocal of 3600 for residues below 2^26 (exact floor division).
	localparam int          ANG_IN_W    = 26;
	localparam int          ANG_SHIFT   = 38;
	localparam int          ANG_QUO_W   = 14;
	localparam logic [63:0] ANG_RECIP_W = ((64'd1 << ANG_SHIFT) / 64'(FULL_TURN)) + 64'd1;
	localparam logic [26:0] ANG_RECIP   = ANG_RECIP_W[26:0];

	// Control fields that travel with a word down the pipeline.
	typedef struct packed {
		logic        kind;
		logic        upd;
		logic [11:0] new_heading;
	} ghi_ctl_t;

endpackage

[src/ghi_integrator.sv]
// Deadband and Simpson-style run integration over the rate samples.
// Holds the integration state; self-contained, no package needed.
`timescale 1ns / 1ps

module ghi_integrator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic        [12:0] deadband,
	input  logic signed [13:0] rate,
	output logic        [31:0] total,
	output logic               upd
);

	localparam logic [1:0]  PHASE_IDLE  = 2'd0;
	localparam logic [1:0]  PHASE_ONE   = 2'd1;
	localparam logic [1:0]  PHASE_THREE = 2'd3;
	localparam logic [16:0] DIV3_RECIP  = 17'd43691;
	localparam int          DIV3_SHIFT  = 17;

	// Truncating division by three of a 16-bit signed value by reciprocal multiply.
	function automatic logic [15:0] div3(input logic [15:0] v);
		logic [15:0] mag;
		logic [32:0] prod;
		logic [15:0] quo;
		mag  = v[15] ? (~v + 16'd1) : v;
		prod = {17'b0, mag} * {16'b0, DIV3_RECIP};
		quo  = prod[DIV3_SHIFT +: 16];
		return v[15] ? (~quo + 16'd1) : quo;
	endfunction

	logic signed [13:0] last_q;
	logic        [1:0]  phase_q;
	logic        [31:0] base_q;
	logic        [31:0] total_q;
	logic        [31:0] odd_q;
	logic        [31:0] even_q;

	logic signed [13:0] last_n;
	logic        [1:0]  phase_n;
	logic        [31:0] base_n;
	logic        [31:0] total_n;
	logic        [31:0] odd_n;
	logic        [31:0] even_n;

	logic signed [14:0] rate_x;
	logic signed [14:0] th_x;
	logic               dead;
	logic signed [13:0] rate_eff;
	logic        [1:0]  phase_eff;
	logic               live;
	logic        [15:0] last16;
	logic        [15:0] last3;
	logic        [15:0] rate16;
	logic        [15:0] term_odd;
	logic        [15:0] term_even;
	logic        [15:0] inc_odd;
	logic        [15:0] inc_even;
	logic        [31:0] odd_acc;
	logic        [31:0] even_acc;
	logic        [31:0] rate32;

	// Deadband, then the two alternating weighted partial sums.
	always_comb begin
		rate_x    = {rate[13], rate};
		th_x      = $signed({2'b00, deadband});
		dead      = (rate_x < th_x) && (rate_x > -th_x);
		rate_eff  = dead ? 14'sd0 : rate;
		phase_eff = dead ? PHASE_IDLE : phase_q;
		live      = (rate_eff != 14'sd0);

		last16    = {{2{last_q[13]}}, last_q};
		last3     = (last16 << 1) + last16;
		rate16    = {{2{rate_eff[13]}}, rate_eff};
		rate32    = {{18{rate_eff[13]}}, rate_eff};
		term_odd  = ((phase_eff == PHASE_THREE) ? last3 : last16) + rate16;
		term_even = ((phase_eff == PHASE_THREE) ? last16 : last3) + rate16;
		inc_odd   = div3(term_odd);
		inc_even  = div3(term_even);
		odd_acc   = odd_q + {{16{inc_odd[15]}}, inc_odd};
		even_acc  = even_q + {{16{inc_even[15]}}, inc_even};

		last_n  = rate_eff;
		phase_n = phase_eff;
		base_n  = base_q;
		total_n = total_q;
		odd_n   = odd_q;
		even_n  = even_q;
		if (live) begin
			if (phase_eff == PHASE_IDLE) begin
				// A new run starts from the total reached so far.
				base_n  = total_q;
				odd_n   = rate32;
				even_n  = 32'd0;
				phase_n = PHASE_THREE;
				total_n = total_q + rate32;
			end else begin
				odd_n   = odd_acc;
				even_n  = even_acc;
				phase_n = (phase_eff == PHASE_THREE) ? PHASE_ONE : PHASE_THREE;
				total_n = base_q + ((phase_eff == PHASE_THREE) ? even_acc : odd_acc);
			end
		end
	end

	assign total = total_n;
	assign upd   = live;

	// Integration state advances once per rate word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			phase_q <= PHASE_IDLE;
			base_q  <= '0;
			total_q <= '0;
			odd_q   <= '0;
			even_q  <= '0;
		end else if (step) begin
			last_q  <= last_n;
			phase_q <= phase_n;
			base_q  <= base_n;
			total_q <= total_n;
			odd_q   <= odd_n;
			even_q  <= even_n;
		end
	end

endmodule

[src/ghi_track.sv]
// Heading offset, wrap and turn counting over the mirrored angle.
// Depends on ghi_pkg for the turn constants and the control struct.
`timescale 1ns / 1ps

module ghi_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ghi_pkg::ghi_ctl_t     ctl,
	input  logic           [11:0] mirrored,
	output logic           [11:0] heading,
	output logic           [15:0] turns
);

	import ghi_pkg::*;

	localparam logic signed [13:0] TURN_S     = $signed({2'b00, FULL_TURN});
	localparam logic signed [13:0] TWO_TURN_S = TURN_S <<< 1;

	logic        [11:0] mir_q;
	logic signed [12:0] off_q;
	logic        [11:0] cur_q;
	logic        [11:0] prev_q;
	logic        [15:0] turns_q;

	logic        [11:0] mir_n;
	logic signed [12:0] off_n;
	logic        [11:0] cur_n;
	logic        [11:0] prev_n;
	logic        [15:0] turns_n;

	logic signed [13:0] sum;
	logic signed [13:0] wrapped;

	// Offset the mirrored angle and bring it back into one turn.
	always_comb begin
		sum = $signed({2'b00, mirrored}) + $signed({off_q[12], off_q});
		if (sum < 14'sd0) begin
			wrapped = sum + TURN_S;
		end else if (sum >= TWO_TURN_S) begin
			wrapped = sum - TWO_TURN_S;
		end else if (sum >= TURN_S) begin
			wrapped = sum - TURN_S;
		end else begin
			wrapped = sum;
		end
	end

	// Next state: a set word moves the offset, a rate word updates and counts turns.
	always_comb begin
		mir_n   = mir_q;
		off_n   = off_q;
		cur_n   = cur_q;
		prev_n  = prev_q;
		turns_n = turns_q;
		if (ctl.kind == KIND_SET) begin
			off_n = $signed({1'b0, ctl.new_heading}) - $signed({1'b0, mir_q});
			cur_n = ctl.new_heading;
		end else begin
			if (ctl.upd) begin
				mir_n = mirrored;
				cur_n = wrapped[11:0];
			end
			if ((prev_q < LOW_EDGE) && (cur_n > HIGH_EDGE)) begin
				turns_n = turns_q - 16'd1;
			end else if ((prev_q > HIGH_EDGE) && (cur_n < LOW_EDGE)) begin
				turns_n = turns_q + 16'd1;
			end
			prev_n = cur_n;
		end
	end

	assign heading = cur_n;
	assign turns   = turns_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mir_q   <= '0;
			off_q   <= '0;
			cur_q   <= '0;
			prev_q  <= '0;
			turns_q <= '0;
		end else if (step) begin
			mir_q   <= mir_n;
			off_q   <= off_n;
			cur_q   <= cur_n;
			prev_q  <= prev_n;
			turns_q <= turns_n;
		end
	end

endmodule

[src/gyro_heading_integrator_core.sv]
// Gyro rate to heading integrator, top level; uses ghi_pkg, ghi_integrator, ghi_track.
// A rate word's result passes through all nine stages before it is offered.
// Throughput: one word per cycle while out_ready holds; set-heading words take a slot but give no result.
// A stalled output lets the pipeline fill its empty stages before input is held off.
// Reset (arst_n low) empties the pipeline, clears the integration and tracking state and sets the deadband to 4.
`timescale 1ns / 1ps

module gyro_heading_integrator_core #(
	parameter int SCALE_DIVISOR = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic        [12:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [13:0] rate_sample,
	input  logic        [11:0] new_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [11:0] heading,
	output logic signed [27:0] unwrapped_heading
);

	import ghi_pkg::*;

	// Exact reciprocal for truncating division of a 32-bit magnitude by SCALE_DIVISOR.
	localparam int          SCALE_LOG     = $clog2(SCALE_DIVISOR);
	localparam int          SCALE_SHIFT   = 32 + SCALE_LOG;
	localparam logic [63:0] SCALE_RECIP_W = ((64'd1 << SCALE_SHIFT) / 64'(SCALE_DIVISOR)) + 64'd1;
	localparam logic [15:0] SCALE_RECIP_LO = SCALE_RECIP_W[15:0];
	localparam logic [16:0] SCALE_RECIP_HI = SCALE_RECIP_W[32:16];

	localparam int STAGES   = 9;
	localparam int ST_INTEG = 1;
	localparam int ST_TRACK = 7;

	// Configuration register.
	logic [12:0] deadband_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_wr_en) begin
			deadband_q <= cfg_wr_data;
		end
	end

	// Pipeline flow control: a stage moves when it is empty or the next one moves.
	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] vld_in;
	logic [STAGES-1:0] adv;
	logic [STAGES-1:0] ld;

	// Payload registers.
	logic               kind_s1;
	logic signed [13:0] rate_s1;
	logic        [11:0] new_heading_s1;
	ghi_ctl_t           ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic        [31:0] total_s2;
	logic               neg_s3, neg_s4, neg_s5, neg_s6;
	logic        [47:0] plo_s3;
	logic        [48:0] phi_s3;
	logic        [31:0] qmag_s4;
	logic [ANG_IN_W-1:0] r1_s5, r1_s6;
	logic [ANG_QUO_W-1:0] quo_s6;
	logic        [11:0] mirrored_s7;
	logic        [11:0] heading_s8;
	logic        [15:0] turns_s8;
	logic        [11:0] heading_s9;
	logic signed [27:0] unwrapped_s9;

	always_comb begin
		adv[STAGES-1] = !vld_q[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
		vld_in[0] = in_valid;
		ld[0]     = in_valid && adv[0];
		for (int k = 1; k < STAGES; k++) begin
			vld_in[k] = vld_q[k-1];
			ld[k]     = vld_q[k-1] && adv[k];
		end
		// Set-heading words end at the tracking stage.
		vld_in[ST_TRACK] = vld_q[ST_TRACK-1] && (ctl_s7.kind == KIND_RATE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[STAGES-1];

	// Stage 1: input register.
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			kind_s1        <= kind;
			rate_s1        <= rate_sample;
			new_heading_s1 <= new_heading;
		end
	end

	// Stage 2: run integration.
	logic        integ_step;
	logic [31:0] integ_total;
	logic        integ_upd;

	assign integ_step = ld[ST_INTEG] && (kind_s1 == KIND_RATE);

	ghi_integrator u_integ (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (integ_step),
		.deadband (deadband_q),
		.rate     (rate_s1),
		.total    (integ_total),
		.upd      (integ_upd)
	);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			ctl_s2.kind        <= kind_s1;
			ctl_s2.upd         <= (kind_s1 == KIND_RATE) && integ_upd;
			ctl_s2.new_heading <= new_heading_s1;
			total_s2           <= integ_total;
		end
	end

	// Stage 3: magnitude times the scale reciprocal, as two partial products.
	logic [31:0] mag_c;
	assign mag_c = total_s2[31] ? (~total_s2 + 32'd1) : total_s2;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			ctl_s3 <= ctl_s2;
			neg_s3 <= total_s2[31];
			plo_s3 <= {16'b0, mag_c} * {32'b0, SCALE_RECIP_LO};
			phi_s3 <= {17'b0, mag_c} * {32'b0, SCALE_RECIP_HI};
		end
	end

	// Stage 4: combine the partial products into the quotient magnitude.
	logic [64:0] prod_c;
	logic [64:0] shifted_c;
	assign prod_c    = {17'b0, plo_s3} + {phi_s3, 16'b0};
	assign shifted_c = prod_c >> SCALE_SHIFT;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			ctl_s4  <= ctl_s3;
			neg_s4  <= neg_s3;
			qmag_s4 <= shifted_c[31:0];
		end
	end

	// Stage 5: fold the upper half so the residue mod 3600 stays below 2^26.
	logic [ANG_IN_W-1:0] r1_c;
	assign r1_c = ({10'b0, qmag_s4[31:16]} * {16'b0, WORD_WRAP}) + {10'b0, qmag_s4[15:0]};

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			ctl_s5 <= ctl_s4;
			neg_s5 <= neg_s4;
			r1_s5  <= r1_c;
		end
	end

	// Stage 6: quotient of the folded value by 3600.
	logic [52:0] aprod_c;
	assign aprod_c = {27'b0, r1_s5} * {26'b0, ANG_RECIP};

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			ctl_s6 <= ctl_s5;
			neg_s6 <= neg_s5;
			r1_s6  <= r1_s5;
			quo_s6 <= aprod_c[ANG_SHIFT +: ANG_QUO_W];
		end
	end

	// Stage 7: remainder and mirror. A negative angle mirrors back onto its own remainder.
	logic [ANG_IN_W-1:0] rem_c;
	logic [11:0]         rem12_c;
	logic [11:0]         mirrored_c;

	always_comb begin
		rem_c   = r1_s6 - ({12'b0, quo_s6} * {14'b0, FULL_TURN});
		rem12_c = rem_c[11:0];
		if (neg_s6 || (rem12_c == 12'd0)) begin
			mirrored_c = rem12_c;
		end else begin
			mirrored_c = FULL_TURN - rem12_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			ctl_s7      <= ctl_s6;
			mirrored_s7 <= mirrored_c;
		end
	end

	// Stage 8: heading state and turn count.
	logic [11:0] track_heading;
	logic [15:0] track_turns;

	ghi_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (ld[ST_TRACK]),
		.ctl      (ctl_s7),
		.mirrored (mirrored_s7),
		.heading  (track_heading),
		.turns    (track_turns)
	);

	always_ff @(posedge clk) begin
		if (ld[ST_TRACK]) begin
			heading_s8 <= track_heading;
			turns_s8   <= track_turns;
		end
	end

	// Stage 9: output register with the unwrapped heading.
	logic signed [27:0] turns_x;
	logic signed [27:0] unwrapped_c;
	assign turns_x     = {{12{turns_s8[15]}}, turns_s8};
	assign unwrapped_c = (turns_x * $signed({16'b0, FULL_TURN})) + $signed({16'b0, heading_s8});

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			heading_s9   <= heading_s8;
			unwrapped_s9 <= unwrapped_c;
		end
	end

	assign heading           = heading_s9;
	assign unwrapped_heading = unwrapped_s9;

endmodule

[src/ghi_checker.sv]
// Port-level assertions for the gyro heading integrator, bound to the top level.
// Depends on ghi_pkg for the word kind codes.
`timescale 1ns / 1ps

module ghi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               kind,
	input logic               out_valid,
	input logic               out_ready,
	input logic        [11:0] heading,
	input logic signed [27:0] unwrapped_heading
);

	import ghi_pkg::*;

	// Rate words accepted whose results have not yet been taken.
	logic [3:0] pending_q;
	logic       take_in;
	logic       take_out;

	assign take_in  = in_valid && in_ready && (kind == KIND_RATE);
	assign take_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (take_in && !take_out) begin
			pending_q <= pending_q + 4'd1;
		end else if (take_out && !take_in) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	// Nothing is offered while reset holds.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	// Every result belongs to an accepted rate word.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 4'd0))
		else $error("result offered with no rate word outstanding");

	// With no rate word in flight the pipeline cannot be blocked.
	a_drained_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 4'd0) |-> in_ready)
		else $error("input held off with no result outstanding");

	// A result that waits stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(heading) && $stable(unwrapped_heading)))
		else $error("waiting result changed or withdrawn");

endmodule

bind gyro_heading_integrator_core ghi_checker u_ghi_checker (.*);

[bench/tb.sv]
// Self-checking bench for gyro_heading_integrator_core: a behavioural predictor of the heading
// pipeline, random handshake gaps on both channels and several deadband settings.
// Depends on src/ghi_pkg.sv and the RTL under src.
`timescale 1ns / 1ps

module tb;
	import ghi_pkg::*;

	localparam int SCALE       = 64;
	localparam int TURN_TENTHS = FULL_TURN;
	localparam int EDGE_LOW    = LOW_EDGE;
	localparam int EDGE_HIGH   = HIGH_EDGE;
	// Cycles allowed for the pipeline to empty once the last result is out.
	localparam int SETTLE      = 16;
	// Cycles without any handshake before the run is declared hung.
	localparam int HANG_LIMIT  = 4000;

	typedef struct packed {
		logic [11:0] hdg;
		logic [27:0] unw;
	} heading_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic        [12:0] cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic               kind;
	logic signed [13:0] rate_sample;
	logic        [11:0] new_heading;
	logic               out_valid;
	logic               out_ready;
	logic        [11:0] heading;
	logic signed [27:0] unwrapped_heading;

	// Expected results in order of acceptance.
	heading_result_t pending_headings[$];

	// Predictor state.
	int      deadband_q;
	int      prev_rate;
	int      phase;
	int      base_sum;
	int      total_sum;
	int      odd_sum;
	int      even_sum;
	int      mirror_ang;
	int      offset_ang;
	int      cur_hdg;
	int      prev_hdg;
	shortint turns;

	bit idle_gaps;
	int err_count;
	int words_sent;
	int results_seen;
	int settings_used;
	int quiet_cycles;

	gyro_heading_integrator_core #(
		.SCALE_DIVISOR(SCALE)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.rate_sample      (rate_sample),
		.new_heading      (new_heading),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.heading          (heading),
		.unwrapped_heading(unwrapped_heading)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result sink with random back-pressure while idle gaps are enabled.
	always @(posedge clk) begin
		out_ready <= !idle_gaps || ($urandom_range(0, 99) >= 33);
	end

	// Hang detection: cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Compare every delivered result with the oldest expectation.
	always @(posedge clk) begin
		heading_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_headings.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result word heading=%0d unwrapped=%0d",
					$time, heading, unwrapped_heading);
			end else begin
				exp_res = pending_headings.pop_front();
				if (heading !== exp_res.hdg) begin
					err_count++;
					$display("%0t: heading mismatch expected %0d actual %0d",
						$time, exp_res.hdg, heading);
				end
				if (unwrapped_heading !== exp_res.unw) begin
					err_count++;
					$display("%0t: unwrapped_heading mismatch expected %0d actual %0d",
						$time, $signed(exp_res.unw), unwrapped_heading);
				end
			end
		end
	end

	function automatic int wrap_angle(input int v);
		int r;
		r = v % TURN_TENTHS;
		if (r < 0)
			r += TURN_TENTHS;
		return r;
	endfunction

	// Advance the predictor by one accepted word and queue its result, if any.
	task automatic predict_heading(input logic k, input logic signed [13:0] r,
			input logic [11:0] h);
		int rate;
		int f;
		int q;
		int unw;
		heading_result_t res;
		if (k == KIND_SET) begin
			offset_ang = int'(h) - mirror_ang;
			cur_hdg = int'(h);
			return;
		end
		rate = int'(r);
		// Samples inside the deadband end the run.
		if (rate < deadband_q && rate > -deadband_q) begin
			rate = 0;
			phase = 0;
		end
		if (rate != 0) begin
			if (phase == 0) begin
				base_sum = total_sum;
				odd_sum = rate;
				even_sum = 0;
				phase = 3;
			end else begin
				f = phase;
				odd_sum += (f * prev_rate + rate) / 3;
				f = 4 - f;
				phase = f;
				even_sum += (f * prev_rate + rate) / 3;
			end
			total_sum = base_sum + ((phase == 3) ? odd_sum : even_sum);
			q = wrap_angle(total_sum / SCALE);
			mirror_ang = (q != 0) ? TURN_TENTHS - q : 0;
			cur_hdg = wrap_angle(mirror_ang + offset_ang);
		end
		prev_rate = rate;
		// Turn counting on crossings near north.
		if (prev_hdg < EDGE_LOW && cur_hdg > EDGE_HIGH)
			turns--;
		if (prev_hdg > EDGE_HIGH && cur_hdg < EDGE_LOW)
			turns++;
		prev_hdg = cur_hdg;
		unw = int'(turns) * TURN_TENTHS + cur_hdg;
		res.hdg = cur_hdg[11:0];
		res.unw = unw[27:0];
		pending_headings.push_back(res);
	endtask

	// Offer one word, with an optional random gap first, and wait for its acceptance.
	task automatic send_word(input logic k, input logic signed [13:0] r, input logic [11:0] h);
		while (idle_gaps && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		rate_sample <= r;
		new_heading <= h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_heading(k, r, h);
		words_sent++;
	endtask

	task automatic send_rate(input logic signed [13:0] r);
		send_word(KIND_RATE, r, 12'($urandom));
	endtask

	task automatic send_set(input logic [11:0] h);
		send_word(KIND_SET, 14'($urandom), h);
	endtask

	// Hold the sender off until every expected result has arrived and the pipeline is empty.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_deadband(input logic [12:0] v);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		deadband_q = int'(v);
		settings_used++;
	endtask

	// Samples right at the reset deadband of four.
	task automatic test_deadband_edges();
		send_rate(14'sd0);
		send_rate(14'sd3);
		send_rate(-14'sd4);
		send_rate(14'sd4);
		send_rate(14'sd5);
	endtask

	// Set heading, including values above the valid range and a tick that keeps them.
	task automatic test_set_heading();
		send_set(12'd1800);
		send_rate(14'sd300);
		send_set(12'd4095);
		send_rate(14'sd0);
		send_rate(14'sd900);
		send_set(12'd0);
	endtask

	task automatic test_field_extremes();
		send_rate(14'sd8191);
		send_rate(14'sd8191);
		send_rate(-14'sd8192);
		send_rate(-14'sd8192);
	endtask

	// With no deadband a zero sample neither updates the heading nor ends the run.
	task automatic test_zero_deadband();
		set_deadband(13'd0);
		send_rate(14'sd6);
		send_rate(14'sd0);
		send_rate(14'sd0);
		send_rate(-14'sd1);
	endtask

	task automatic test_full_deadband();
		set_deadband(13'd8191);
		send_rate(14'sd8191);
		send_rate(14'sd8190);
		send_rate(-14'sd8192);
		send_rate(-14'sd8191);
	endtask

	// Random segments: steady turns, deadband noise, wild samples, reversals and zeros.
	task automatic test_random_traffic(input logic [12:0] threshold, input int n_words,
			input bit gaps);
		int seg_left;
		int mode;
		int sgn;
		int mag;
		int lim;
		set_deadband(threshold);
		idle_gaps = gaps;
		seg_left = 0;
		mode = 0;
		sgn = 0;
		for (int i = 0; i < n_words; i++) begin
			if (seg_left == 0) begin
				mode = $urandom_range(0, 9);
				seg_left = $urandom_range(5, 60);
				sgn = $urandom_range(0, 1);
			end
			seg_left--;
			if ($urandom_range(0, 99) < 8) begin
				if ($urandom_range(0, 4) == 0)
					send_set(12'($urandom_range(3600, 4095)));
				else
					send_set(12'($urandom_range(0, 3599)));
			end else begin
				case (mode)
					0, 1, 2, 3, 4: mag = $urandom_range(2000, 8191);
					5, 6: begin
						lim = 2 * deadband_q + 2;
						if (lim > 8191)
							lim = 8191;
						mag = $urandom_range(0, lim);
						sgn = $urandom_range(0, 1);
					end
					7: begin
						mag = 0;
						send_rate(14'($urandom));
					end
					8: begin
						mag = $urandom_range(4000, 8191);
						sgn = !sgn;
					end
					default: mag = 0;
				endcase
				if (mode != 7)
					send_rate(14'(sgn ? -mag : mag));
			end
		end
		idle_gaps = 1'b1;
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b1;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		in_valid     = 1'b0;
		kind         = KIND_RATE;
		rate_sample  = '0;
		new_heading  = '0;
		out_ready    = 1'b0;
		idle_gaps    = 1'b1;
		err_count    = 0;
		words_sent   = 0;
		results_seen = 0;
		settings_used = 0;
		quiet_cycles = 0;
		deadband_q   = DEADBAND_RESET;
		prev_rate    = 0;
		phase        = 0;
		base_sum     = 0;
		total_sum    = 0;
		odd_sum      = 0;
		even_sum     = 0;
		mirror_ang   = 0;
		offset_ang   = 0;
		cur_hdg      = 0;
		prev_hdg     = 0;
		turns        = 0;

		// Assert reset just after time zero so the falling edge is always seen.
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_deadband_edges();
		test_set_heading();
		test_field_extremes();
		test_zero_deadband();
		test_full_deadband();
		test_random_traffic(13'd4, 200, 1'b1);
		test_random_traffic(13'd0, 200, 1'b1);
		test_random_traffic(13'd8191, 200, 1'b1);
		test_random_traffic(13'd1, 200, 1'b1);
		test_random_traffic(13'd60, 200, 1'b0);
		test_random_traffic(13'($urandom_range(0, 8191)), 200, 1'b1);
		test_random_traffic(13'd2000, 200, 1'b1);
		drain_pipeline();

		$display("Sent %0d words under %0d deadband settings; %0d results checked, turn count %0d.",
			words_sent, settings_used, results_seen, turns);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
